>>> design/jsu_pkg.sv
package jsu_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Default depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One input item
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_type;

   // All results caused by one input item
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [1:0]      kind;
   } burst_type;

endpackage

>>> design/jsu_front.sv
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  jsu_pkg::req_type   req_payload,
   output logic               req_stall,
   input  logic               q_full,
   output logic               q_push,
   output jsu_pkg::burst_type q_data
);
   import jsu_pkg::*;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_STR  = 7'b0000010,
      PH_ESC  = 7'b0000100,
      PH_HEX1 = 7'b0001000,
      PH_BSL2 = 7'b0010000,
      PH_U2   = 7'b0100000,
      PH_HEX2 = 7'b1000000
   } phase_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [5:0] TAG_HIGH = 6'b110110;
   localparam logic [5:0] TAG_LOW  = 6'b110111;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_unit_ff, code_unit_in;
   logic [9:0]  high_part_ff, high_part_in;

   logic        accept;
   logic [7:0]  c;
   logic        eot;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cu;
   logic        do_emit;
   logic        do_fail;
   logic        do_byte;
   logic        do_done;
   logic [7:0]  byte_val;
   logic [20:0] cp;
   burst_type   enc;

   // Encode one code point as UTF-8
   function automatic burst_type utf8_encode(input logic [20:0] p);
      burst_type b;
      b = '0;
      b.kind = KIND_BYTE;
      if (p <= 21'h7F) begin
         b.bytes[0] = p[7:0];
         b.last_idx = 2'd0;
      end else if (p <= 21'h7FF) begin
         b.bytes[0] = {3'b110, p[10:6]};
         b.bytes[1] = {2'b10, p[5:0]};
         b.last_idx = 2'd1;
      end else if (p <= 21'hFFFF) begin
         b.bytes[0] = {4'b1110, p[15:12]};
         b.bytes[1] = {2'b10, p[11:6]};
         b.bytes[2] = {2'b10, p[5:0]};
         b.last_idx = 2'd2;
      end else begin
         b.bytes[0] = {5'b11110, p[20:18]};
         b.bytes[1] = {2'b10, p[17:12]};
         b.bytes[2] = {2'b10, p[11:6]};
         b.bytes[3] = {2'b10, p[5:0]};
         b.last_idx = 2'd3;
      end
      return b;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_payload.char_byte;
   assign eot       = req_payload.end_of_text;

   // Decode a hex digit
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cu = {code_unit_ff[11:0], hex_val};

   // Advance the scanner and classify the item
   always_comb begin
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      code_unit_in = code_unit_ff;
      high_part_in = high_part_ff;
      do_emit      = 1'b0;
      do_fail      = 1'b0;
      do_byte      = 1'b0;
      do_done      = 1'b0;
      byte_val     = c;
      cp           = {5'd0, cu};
      if (phase_ff != PH_IDLE && eot &&
          (phase_ff == PH_STR || phase_ff == PH_ESC || phase_ff == PH_HEX1 ||
           phase_ff == PH_BSL2 || phase_ff == PH_U2 || phase_ff == PH_HEX2)) begin
         do_fail = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_STR: begin
               if (c == CH_QUOTE) begin
                  do_done  = 1'b1;
                  phase_in = PH_IDLE;
               end else if (c == CH_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  do_byte = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in = PH_STR;
               do_byte  = 1'b1;
               priority if (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH) begin
                  byte_val = c;
               end else if (c == CH_B) begin
                  byte_val = 8'h08;
               end else if (c == CH_F) begin
                  byte_val = 8'h0C;
               end else if (c == CH_N) begin
                  byte_val = 8'h0A;
               end else if (c == CH_R) begin
                  byte_val = 8'h0D;
               end else if (c == CH_T) begin
                  byte_val = 8'h09;
               end else if (c == CH_U) begin
                  do_byte      = 1'b0;
                  phase_in     = PH_HEX1;
                  hex_count_in = 2'd0;
                  code_unit_in = 16'd0;
               end else begin
                  do_byte = 1'b0;
                  do_fail = 1'b1;
               end
            end
            PH_BSL2: begin
               if (c != CH_BSL) begin
                  do_fail = 1'b1;
               end else begin
                  phase_in = PH_U2;
               end
            end
            PH_U2: begin
               if (c != CH_U) begin
                  do_fail = 1'b1;
               end else begin
                  phase_in     = PH_HEX2;
                  hex_count_in = 2'd0;
                  code_unit_in = 16'd0;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (!hex_ok) begin
                  do_fail = 1'b1;
               end else if (hex_count_ff != 2'd3) begin
                  hex_count_in = hex_count_ff + 2'd1;
                  code_unit_in = cu;
               end else begin
                  hex_count_in = 2'd0;
                  code_unit_in = 16'd0;
                  if (phase_ff == PH_HEX1) begin
                     if (cu[15:10] == TAG_HIGH) begin
                        high_part_in = cu[9:0];
                        phase_in     = PH_BSL2;
                     end else if (cu[15:10] == TAG_LOW) begin
                        do_fail = 1'b1;
                     end else begin
                        phase_in = PH_STR;
                        do_emit  = 1'b1;
                     end
                  end else begin
                     if (cu[15:10] != TAG_LOW) begin
                        do_fail = 1'b1;
                     end else begin
                        cp           = {1'b0, high_part_ff, cu[9:0]} + SUPP_BASE;
                        high_part_in = 10'd0;
                        phase_in     = PH_STR;
                        do_emit      = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // idle, and any stray code treated as idle
               phase_in     = PH_IDLE;
               hex_count_in = 2'd0;
               code_unit_in = 16'd0;
               high_part_in = 10'd0;
               if (!eot) begin
                  if (c == CH_QUOTE) begin
                     phase_in = PH_STR;
                  end else if (!(c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D))) begin
                     do_fail = 1'b1;
                  end
               end
            end
         endcase
      end
      if (do_fail) begin
         phase_in     = PH_IDLE;
         hex_count_in = 2'd0;
         code_unit_in = 16'd0;
         high_part_in = 10'd0;
      end
   end

   assign enc = utf8_encode(cp);

   // Build the queue entry
   always_comb begin
      q_data = '0;
      if (do_emit) begin
         q_data = enc;
      end else if (do_byte) begin
         q_data.bytes[0] = byte_val;
         q_data.kind     = KIND_BYTE;
      end else if (do_done) begin
         q_data.kind = KIND_DONE;
      end else begin
         q_data.kind = KIND_ERROR;
      end
   end

   assign q_push = accept && (do_emit || do_byte || do_done || do_fail);

   // Hold scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hex_count_ff <= 2'd0;
         code_unit_ff <= 16'd0;
         high_part_ff <= 10'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_count_ff <= hex_count_in;
         code_unit_ff <= code_unit_in;
         high_part_ff <= high_part_in;
      end
   end

endmodule

>>> design/jsu_queue.sv
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::burst_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output jsu_pkg::burst_type head
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   burst_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/jsu_back.sv
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  jsu_pkg::burst_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output jsu_pkg::rsp_type   rsp_payload
);
   import jsu_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_last;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign at_last = (idx_ff == q_head.last_idx);
   assign q_pop   = load && q_not_empty && at_last;

   // Walk the bytes of the head entry, one result per cycle while rsp_stall is low
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in     = q_not_empty;
         rsp_in.out_byte  = q_head.bytes[idx_ff];
         rsp_in.kind      = q_head.kind;
         rsp_in.last      = at_last;
         if (q_not_empty) begin
            idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold the output item
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output.
// req channel: one text byte per item (char_byte), or an end-of-text marker
// (end_of_text). Whitespace before an opening quote is skipped; string bytes
// pass through; escapes and \uXXXX (with surrogate pairs) are decoded.
// rsp channel: result items with kind byte, done (closing quote) or error;
// last marks the final result caused by one req item. After an error the
// bytes already delivered for that string should be dropped by the user.
// Path: the results of an accepted item are written into the queue, then the
// output register presents them, one result per cycle while rsp_stall is low.
// Throughput: one req item per cycle while req_stall is low. Each code point
// yields one result per UTF-8 byte (up to four); the queue between the scanner
// and the output serializer (QUEUE_DEPTH entries) absorbs these bursts, and
// req_stall rises only when that queue is full.
// Reset: synchronous, active high; the scanner returns to idle and the queue
// and output register empty.
// rsp_stall holds the output register; the scanner keeps taking items until
// the queue fills.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jsu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jsu_pkg::rsp_type rsp_payload
);
   import jsu_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   burst_type q_data;
   burst_type q_head;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
